### hw/rtl/qps_pkg.sv
// Package for the two-axis quadrature PD servo.
// Holds widths, opcodes, register indexes and the quadrature step table.
// Depends on nothing.
`default_nettype none

package qps_pkg;

   localparam int POS_BITS   = 32;
   localparam int DIFF_BITS  = POS_BITS + 1;
   localparam int GAIN_BITS  = 16;
   localparam int DRV_BITS   = POS_BITS + GAIN_BITS + 3;
   localparam int RATIO_BITS = 16;
   localparam int TGT_BITS   = 32;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   typedef logic [2:0]                  opcode_type;
   typedef logic [1:0]                  pins_type;
   typedef logic signed [TGT_BITS-1:0]  target_type;
   typedef logic [POS_BITS-1:0]         pos_type;
   typedef logic signed [POS_BITS-1:0]  err_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [DRV_BITS-1:0]  drive_type;
   typedef logic [GAIN_BITS-1:0]        gain_type;
   typedef logic [RATIO_BITS-1:0]       ratio_type;
   typedef logic signed [2:0]           step_type;

   localparam opcode_type OP_X_EDGE  = 3'd0;
   localparam opcode_type OP_Y_EDGE  = 3'd1;
   localparam opcode_type OP_TICK    = 3'd2;
   localparam opcode_type OP_ENABLE  = 3'd3;
   localparam opcode_type OP_DISABLE = 3'd4;
   localparam opcode_type OP_SEED    = 3'd5;

   localparam logic REG_GAIN_P = 1'b0;
   localparam logic REG_GAIN_D = 1'b1;

   localparam gain_type  GAIN_P_RESET = 16'd5000;
   localparam gain_type  GAIN_D_RESET = 16'd24000;
   localparam ratio_type RATIO_OFF    = 16'hFFFF;
   localparam step_type  QUAD_ERR     = 3'sb011;

   localparam step_type STEP_TABLE [64] = '{
      3'b000, 3'b001, 3'b111, 3'b011,  3'b111, 3'b000, 3'b010, 3'b001,
      3'b001, 3'b110, 3'b000, 3'b111,  3'b011, 3'b111, 3'b001, 3'b000,
      3'b000, 3'b001, 3'b111, 3'b110,  3'b111, 3'b000, 3'b011, 3'b001,
      3'b001, 3'b011, 3'b000, 3'b111,  3'b010, 3'b111, 3'b001, 3'b000,
      3'b000, 3'b001, 3'b111, 3'b010,  3'b111, 3'b000, 3'b011, 3'b001,
      3'b001, 3'b011, 3'b000, 3'b111,  3'b110, 3'b111, 3'b001, 3'b000,
      3'b000, 3'b001, 3'b111, 3'b011,  3'b111, 3'b000, 3'b110, 3'b001,
      3'b001, 3'b010, 3'b000, 3'b111,  3'b011, 3'b111, 3'b001, 3'b000
   };

endpackage

`default_nettype wire

### hw/rtl/qps_chan_if.sv
// Valid/ready channel interfaces for the servo request and response beats.
// Depends on qps_pkg.
`default_nettype none

interface qps_req_if;
   import qps_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   pins_type   x_pins;
   pins_type   y_pins;
   target_type target_x;
   target_type target_y;
   modport source (output valid, opcode, x_pins, y_pins, target_x, target_y, input ready);
   modport sink (input valid, opcode, x_pins, y_pins, target_x, target_y, output ready);
endinterface

interface qps_rsp_if;
   import qps_pkg::*;
   logic      valid;
   logic      ready;
   ratio_type x_drive_fwd;
   ratio_type x_drive_rev;
   ratio_type y_drive_fwd;
   ratio_type y_drive_rev;
   modport source (output valid, x_drive_fwd, x_drive_rev, y_drive_fwd, y_drive_rev,
                   input ready);
   modport sink (input valid, x_drive_fwd, x_drive_rev, y_drive_fwd, y_drive_rev,
                 output ready);
endinterface

`default_nettype wire

### hw/rtl/quadrature_pd_servo_two_axis.sv
// Top level of the two-axis quadrature PD servo with its register port.
// Depends on qps_pkg and the channel interfaces in qps_chan_if.
`default_nettype none

// Channel   Direction  Handshake            Contents
// req_ch    in         valid/ready          opcode, pin samples, targets
// rsp_ch    out        valid/ready          four H-bridge ratios
// csr_*     in         APB write/read       gain_p at 0x0, gain_d at 0x4
//
// One request per cycle unless stalled; decoder and error state update at accept.
// Tick and disable beats pass the error, multiply and response registers in turn.
// The multiply stage and the saturate stage each hold one beat and slip past bubbles.
// Reset restores the gains, clears positions and errors and sets the servo running.

module quadrature_pd_servo_two_axis (
   input  wire                        clock,
   input  wire                        reset,
   qps_req_if.sink                    req_ch,
   qps_rsp_if.source                  rsp_ch,
   input  wire                        csr_psel,
   input  wire                        csr_penable,
   input  wire                        csr_pwrite,
   input  wire [qps_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire [qps_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [qps_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                       csr_pready
);
   import qps_pkg::*;

   gain_type gain_p_ff, gain_d_ff;

   pins_type x_now_ff, x_before_ff, y_now_ff, y_before_ff;
   pos_type  x_pos_ff, y_pos_ff;
   err_type  x_last_ff, y_last_ff;
   logic     running_ff;

   pins_type x_now_in, x_before_in, y_now_in, y_before_in;
   pos_type  x_pos_in, y_pos_in;
   err_type  x_last_in, y_last_in;
   logic     running_in;

   logic     s1_valid_ff, s1_idle_ff;
   err_type  s1_ex_ff, s1_ey_ff;
   diff_type s1_dx_ff, s1_dy_ff;

   logic      s2_valid_ff, s2_idle_ff;
   drive_type s2_px_ff, s2_dx_ff, s2_py_ff, s2_dy_ff;

   logic      rsp_valid_ff;
   ratio_type x_fwd_ff, x_rev_ff, y_fwd_ff, y_rev_ff;

   logic      out_free, s2_take, s1_take, accept, result_in, idle_in;
   err_type   ex, ey;
   diff_type  dx, dy;
   step_type  x_step, y_step;
   drive_type drive_x, drive_y;
   ratio_type x_fwd_in, x_rev_in, y_fwd_in, y_rev_in;

   function automatic logic [2*RATIO_BITS-1:0] bridge(input drive_type drv);
      drive_type mag;
      ratio_type ratio;
      logic      positive;
      mag      = drv[DRV_BITS-1] ? -drv : drv;
      positive = !drv[DRV_BITS-1] && (drv != '0);
      if ((mag[DRV_BITS-1:RATIO_BITS] != '0) || (mag[RATIO_BITS-1:0] == RATIO_OFF)) begin
         ratio = '0;
      end else begin
         ratio = ~mag[RATIO_BITS-1:0];
      end
      if (positive) begin
         bridge = {ratio, RATIO_OFF};
      end else begin
         bridge = {RATIO_OFF, ratio};
      end
   endfunction

   // Register port.
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_GAIN_P: csr_prdata[GAIN_BITS-1:0] = gain_p_ff;
         REG_GAIN_D: csr_prdata[GAIN_BITS-1:0] = gain_d_ff;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= GAIN_P_RESET;
         gain_d_ff <= GAIN_D_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == REG_GAIN_P) begin
            gain_p_ff <= csr_pwdata[GAIN_BITS-1:0];
         end else begin
            gain_d_ff <= csr_pwdata[GAIN_BITS-1:0];
         end
      end
   end

   // Flow control.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s2_take      = !s2_valid_ff || out_free;
   assign s1_take      = !s1_valid_ff || s2_take;
   assign req_ch.ready = s1_take;
   assign accept       = req_ch.valid && s1_take;

   // Decoder and error state, updated at accept.
   assign x_step = STEP_TABLE[{x_before_ff, x_now_ff, req_ch.x_pins}];
   assign y_step = STEP_TABLE[{y_before_ff, y_now_ff, req_ch.y_pins}];
   assign ex = err_type'(req_ch.target_x[POS_BITS-1:0] - x_pos_ff);
   assign ey = err_type'(req_ch.target_y[POS_BITS-1:0] - y_pos_ff);
   assign dx = diff_type'(ex) - diff_type'(x_last_ff);
   assign dy = diff_type'(ey) - diff_type'(y_last_ff);

   always_comb begin
      x_now_in    = x_now_ff;
      x_before_in = x_before_ff;
      y_now_in    = y_now_ff;
      y_before_in = y_before_ff;
      x_pos_in    = x_pos_ff;
      y_pos_in    = y_pos_ff;
      x_last_in   = x_last_ff;
      y_last_in   = y_last_ff;
      running_in  = running_ff;
      result_in   = 1'b0;
      idle_in     = 1'b0;
      unique case (req_ch.opcode)
         OP_X_EDGE: begin
            x_before_in = x_now_ff;
            x_now_in    = req_ch.x_pins;
            if (x_step != QUAD_ERR) begin
               x_pos_in = x_pos_ff + pos_type'(x_step);
            end
         end
         OP_Y_EDGE: begin
            y_before_in = y_now_ff;
            y_now_in    = req_ch.y_pins;
            if (y_step != QUAD_ERR) begin
               y_pos_in = y_pos_ff + pos_type'(y_step);
            end
         end
         OP_TICK: begin
            if (running_ff) begin
               x_last_in = ex;
               y_last_in = ey;
               result_in = 1'b1;
            end
         end
         OP_ENABLE: begin
            x_last_in  = '0;
            y_last_in  = '0;
            running_in = 1'b1;
         end
         OP_DISABLE: begin
            running_in = 1'b0;
            result_in  = 1'b1;
            idle_in    = 1'b1;
         end
         OP_SEED: begin
            x_now_in    = req_ch.x_pins;
            x_before_in = req_ch.x_pins;
            y_now_in    = req_ch.y_pins;
            y_before_in = req_ch.y_pins;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_now_ff    <= '0;
         x_before_ff <= '0;
         y_now_ff    <= '0;
         y_before_ff <= '0;
         x_pos_ff    <= '0;
         y_pos_ff    <= '0;
         x_last_ff   <= '0;
         y_last_ff   <= '0;
         running_ff  <= 1'b1;
      end else if (accept) begin
         x_now_ff    <= x_now_in;
         x_before_ff <= x_before_in;
         y_now_ff    <= y_now_in;
         y_before_ff <= y_before_in;
         x_pos_ff    <= x_pos_in;
         y_pos_ff    <= y_pos_in;
         x_last_ff   <= x_last_in;
         y_last_ff   <= y_last_in;
         running_ff  <= running_in;
      end
   end

   // Error stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_take) begin
         s1_valid_ff <= accept && result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_idle_ff <= idle_in;
         s1_ex_ff   <= ex;
         s1_ey_ff   <= ey;
         s1_dx_ff   <= dx;
         s1_dy_ff   <= dy;
      end
   end

   // Multiply stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_take) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take) begin
         s2_idle_ff <= s1_idle_ff;
         s2_px_ff   <= $signed({1'b0, gain_p_ff}) * drive_type'(s1_ex_ff);
         s2_py_ff   <= $signed({1'b0, gain_p_ff}) * drive_type'(s1_ey_ff);
         s2_dx_ff   <= $signed({1'b0, gain_d_ff}) * drive_type'(s1_dx_ff);
         s2_dy_ff   <= $signed({1'b0, gain_d_ff}) * drive_type'(s1_dy_ff);
      end
   end

   // Sum and saturate into the response register.
   assign drive_x = s2_px_ff + s2_dx_ff;
   assign drive_y = s2_py_ff + s2_dy_ff;

   always_comb begin
      if (s2_idle_ff) begin
         x_fwd_in = RATIO_OFF;
         x_rev_in = RATIO_OFF;
         y_fwd_in = RATIO_OFF;
         y_rev_in = RATIO_OFF;
      end else begin
         {x_fwd_in, x_rev_in} = bridge(drive_x);
         {y_fwd_in, y_rev_in} = bridge(drive_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         x_fwd_ff <= x_fwd_in;
         x_rev_ff <= x_rev_in;
         y_fwd_ff <= y_fwd_in;
         y_rev_ff <= y_rev_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.x_drive_fwd = x_fwd_ff;
   assign rsp_ch.x_drive_rev = x_rev_ff;
   assign rsp_ch.y_drive_fwd = y_fwd_ff;
   assign rsp_ch.y_drive_rev = y_rev_ff;

endmodule

`default_nettype wire

### dv/quadrature_pd_servo_two_axis_tb.sv
// Testbench for the two-axis quadrature PD servo: decoder steps, ticks, enable and disable.
// Predicts every drive beat from its own decoder and PD model and checks it against the DUT.
// Depends on qps_pkg, the channel interfaces and the quadrature_pd_servo_two_axis RTL.
`timescale 1ns / 1ps

module quadrature_pd_servo_two_axis_tb;
   import qps_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int MAX_PRINTS     = 40;
   localparam int AXIS_X         = 0;
   localparam int AXIS_Y         = 1;
   localparam int STEP_INVALID   = 3;

   // Indexed by {previous sample, current sample, new sample}.
   localparam int QUAD_STEP [64] = '{
      0, 1, -1, 3,   -1, 0, 2, 1,    1, -2, 0, -1,   3, -1, 1, 0,
      0, 1, -1, -2,  -1, 0, 3, 1,    1, 3, 0, -1,    2, -1, 1, 0,
      0, 1, -1, 2,   -1, 0, 3, 1,    1, 3, 0, -1,    -2, -1, 1, 0,
      0, 1, -1, 3,   -1, 0, -2, 1,   1, 2, 0, -1,    3, -1, 1, 0
   };

   typedef struct packed {
      ratio_type x_fwd;
      ratio_type x_rev;
      ratio_type y_fwd;
      ratio_type y_rev;
   } drive_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   qps_req_if req_ch ();
   qps_rsp_if rsp_ch ();

   quadrature_pd_servo_two_axis dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   gain_type       gain_p_model;
   gain_type       gain_d_model;
   pins_type       quad_now [2];
   pins_type       quad_prev [2];
   pos_type        axis_pos [2];
   err_type        axis_last_err [2];
   logic           servo_on;
   drive_beat_type expected_drives [$];
   drive_beat_type got_beat;
   drive_beat_type want_beat;

   int     error_count      = 0;
   int     commands_sent    = 0;
   int     drives_checked   = 0;
   int     saturated_drives = 0;
   int     decoder_faults   = 0;
   int     gain_settings    = 0;
   int     burst_left       = 0;
   bit     sender_gaps      = 1'b0;
   bit     receiver_stalls  = 1'b0;
   int     hold_off_request = 0;
   int     hold_left        = 0;
   int     run_left         = 0;
   int     run_kind         = 0;
   longint cycle_count      = 0;

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) $display("%0t ns: ERROR %s", $time, msg);
   endtask

   function automatic void quad_decode(int ax, pins_type pins);
      int delta_pos;
      delta_pos = QUAD_STEP[{quad_prev[ax], quad_now[ax], pins}];
      quad_prev[ax] = quad_now[ax];
      quad_now[ax] = pins;
      if (delta_pos == STEP_INVALID) begin
         decoder_faults++;
      end else begin
         axis_pos[ax] = axis_pos[ax] + pos_type'(delta_pos);
      end
   endfunction

   function automatic void axis_drive(int ax, target_type tgt,
                                      output ratio_type fwd, output ratio_type rev);
      err_type   e;
      longint    drive;
      longint    mag;
      ratio_type level;
      e = err_type'(pos_type'(tgt) - axis_pos[ax]);
      drive = longint'(gain_p_model) * longint'(e)
            + longint'(gain_d_model) * (longint'(e) - longint'(axis_last_err[ax]));
      mag = (drive > 0) ? drive : -drive;
      if (mag >= longint'(RATIO_OFF)) begin
         level = '0;
         saturated_drives++;
      end else begin
         level = ratio_type'(longint'(RATIO_OFF) - mag);
      end
      axis_last_err[ax] = e;
      if (drive > 0) begin
         fwd = level;
         rev = RATIO_OFF;
      end else begin
         fwd = RATIO_OFF;
         rev = level;
      end
   endfunction

   function automatic void predict_command(opcode_type op, pins_type xp, pins_type yp,
                                           target_type tx, target_type ty);
      ratio_type xf, xr, yf, yr;
      case (op)
         OP_X_EDGE: begin
            quad_decode(AXIS_X, xp);
         end
         OP_Y_EDGE: begin
            quad_decode(AXIS_Y, yp);
         end
         OP_TICK: begin
            if (servo_on) begin
               axis_drive(AXIS_X, tx, xf, xr);
               axis_drive(AXIS_Y, ty, yf, yr);
               expected_drives.push_back({xf, xr, yf, yr});
            end
         end
         OP_ENABLE: begin
            axis_last_err[AXIS_X] = '0;
            axis_last_err[AXIS_Y] = '0;
            servo_on = 1'b1;
         end
         OP_DISABLE: begin
            servo_on = 1'b0;
            expected_drives.push_back({4{RATIO_OFF}});
         end
         OP_SEED: begin
            quad_now[AXIS_X] = xp;
            quad_prev[AXIS_X] = xp;
            quad_now[AXIS_Y] = yp;
            quad_prev[AXIS_Y] = yp;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic target_type near_target(int ax);
      int k;
      k = $urandom_range(0, 99);
      if (k < 15) return target_type'($urandom);
      if (k < 25) return target_type'(axis_pos[ax]);
      return target_type'(axis_pos[ax] + pos_type'(int'($urandom_range(0, 40)) - 20));
   endfunction

   task automatic send_cmd(opcode_type op, pins_type xp, pins_type yp,
                           target_type tx, target_type ty);
      int gap;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_ch.valid    <= 1'b1;
      req_ch.opcode   <= op;
      req_ch.x_pins   <= xp;
      req_ch.y_pins   <= yp;
      req_ch.target_x <= tx;
      req_ch.target_y <= ty;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_command(op, xp, yp, tx, ty);
      if (op <= OP_SEED) commands_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(logic which, gain_type value);
      logic [DATA_BITS-1:0] readback;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (which == REG_GAIN_P) gain_p_model = value;
      else gain_d_model = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback != DATA_BITS'(value)) begin
         report_error($sformatf("gain register %0d reads %h, written %h",
                                which, readback, value));
      end
   endtask

   task automatic set_gains(gain_type p, gain_type d);
      settle();
      write_gain(REG_GAIN_P, p);
      write_gain(REG_GAIN_D, d);
      gain_settings++;
   endtask

   task automatic send_random_cmd();
      int         pick;
      int         ax;
      pins_type   xp, yp, pins;
      target_type tx, ty;
      opcode_type op;
      xp = pins_type'($urandom_range(0, 3));
      yp = pins_type'($urandom_range(0, 3));
      tx = near_target(AXIS_X);
      ty = near_target(AXIS_Y);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         ax = $urandom_range(0, 1);
         op = (ax == AXIS_X) ? OP_X_EDGE : OP_Y_EDGE;
         pins = quad_now[ax];
         if ($urandom_range(0, 99) < 85) begin
            // Gray-code neighbor in either direction.
            if ($urandom_range(0, 1)) pins = {pins[0], ~pins[1]};
            else pins = {~pins[0], pins[1]};
         end else begin
            pins = pins_type'($urandom_range(0, 3));
         end
         if (ax == AXIS_X) xp = pins;
         else yp = pins;
      end else if (pick < 82) begin
         op = OP_TICK;
      end else if (pick < 86) begin
         op = OP_ENABLE;
      end else if (pick < 89) begin
         op = OP_DISABLE;
      end else if (pick < 92) begin
         op = OP_SEED;
      end else if (pick < 95) begin
         op = opcode_type'($urandom_range(6, 7));
      end else begin
         op = opcode_type'($urandom_range(0, 7));
         tx = target_type'($urandom);
         ty = target_type'($urandom);
      end
      send_cmd(op, xp, yp, tx, ty);
   endtask

   task automatic run_random(int count);
      int start;
      start = commands_sent;
      while (commands_sent - start < count) send_random_cmd();
   endtask

   task automatic test_decoder_edges();
      send_cmd(OP_TICK, 2'b00, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b01, 2'b11, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b11, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b10, 2'b11, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b00, 2'b01, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b10, 2'b10, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b01, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b01, 2'b11, 32'sd0, 32'sd0);
      send_cmd(OP_SEED, 2'b11, 2'b10, 32'sd0, 32'sd0);
      send_cmd(OP_Y_EDGE, 2'b00, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_Y_EDGE, 2'b11, 2'b11, 32'sd0, 32'sd0);
      send_cmd(OP_TICK, 2'b10, 2'b01, 32'sh7FFF_FFFF, 32'sh8000_0000);
   endtask

   task automatic test_servo_modes();
      send_cmd(OP_SEED, 2'b00, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b10, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_X_EDGE, 2'b11, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_Y_EDGE, 2'b00, 2'b01, 32'sd0, 32'sd0);
      send_cmd(OP_Y_EDGE, 2'b00, 2'b11, 32'sd0, 32'sd0);
      send_cmd(OP_TICK, 2'b11, 2'b11, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_cmd(OP_DISABLE, 2'b01, 2'b10, 32'sd5, -32'sd5);
      send_cmd(OP_TICK, 2'b00, 2'b00, 32'sd100, 32'sd100);
      send_cmd(opcode_type'(6), 2'b11, 2'b11, 32'sd1, 32'sd1);
      send_cmd(opcode_type'(7), 2'b00, 2'b00, -32'sd1, -32'sd1);
      send_cmd(OP_ENABLE, 2'b00, 2'b00, 32'sd0, 32'sd0);
      send_cmd(OP_ENABLE, 2'b11, 2'b11, 32'sd0, 32'sd0);
      send_cmd(OP_TICK, 2'b00, 2'b00, target_type'(axis_pos[AXIS_X]),
               target_type'(axis_pos[AXIS_Y]));
   endtask

   task automatic test_gain_sweep();
      gain_type p_list [9];
      gain_type d_list [9];
      p_list = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, GAIN_P_RESET};
      d_list = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, GAIN_D_RESET};
      p_list[6] = gain_type'($urandom_range(0, 40));
      d_list[6] = gain_type'($urandom_range(0, 40));
      p_list[7] = gain_type'($urandom_range(0, 65535));
      d_list[7] = gain_type'($urandom_range(0, 65535));
      foreach (p_list[i]) begin
         set_gains(p_list[i], d_list[i]);
         sender_gaps = 1'($urandom_range(0, 1));
         receiver_stalls = 1'($urandom_range(0, 1));
         run_random(70);
      end
   endtask

   task automatic test_backpressure();
      settle();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      send_cmd(OP_ENABLE, 2'b00, 2'b00, 32'sd0, 32'sd0);
      hold_off_request = 300;
      repeat (80) begin
         send_cmd(OP_TICK, pins_type'($urandom_range(0, 3)), pins_type'($urandom_range(0, 3)),
                  near_target(AXIS_X), near_target(AXIS_Y));
      end
      settle();
   endtask

   task automatic test_random_traffic();
      set_gains(pins_type'($urandom_range(0, 3)) * 16'd7 + 16'd2,
                gain_type'($urandom_range(0, 60)));
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      run_random(150);
   endtask

   always @(posedge clock) begin
      if (hold_off_request != 0) begin
         hold_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_left = $urandom_range(1, 24);
            run_kind = receiver_stalls ? $urandom_range(0, 2) : 0;
         end
         run_left--;
         case (run_kind)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'b0;
            default: rsp_ch.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_beat = {rsp_ch.x_drive_fwd, rsp_ch.x_drive_rev,
                     rsp_ch.y_drive_fwd, rsp_ch.y_drive_rev};
         if (expected_drives.size() == 0) begin
            report_error($sformatf("drive beat %h with nothing expected", got_beat));
         end else begin
            want_beat = expected_drives.pop_front();
            drives_checked++;
            if (got_beat.x_fwd != want_beat.x_fwd || got_beat.x_rev != want_beat.x_rev ||
                got_beat.y_fwd != want_beat.y_fwd || got_beat.y_rev != want_beat.y_rev) begin
               report_error($sformatf(
                  "beat %0d: x %0d/%0d y %0d/%0d, expected x %0d/%0d y %0d/%0d",
                  drives_checked, got_beat.x_fwd, got_beat.x_rev, got_beat.y_fwd,
                  got_beat.y_rev, want_beat.x_fwd, want_beat.x_rev, want_beat.y_fwd,
                  want_beat.y_rev));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("quadrature_pd_servo_two_axis_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.opcode   <= OP_X_EDGE;
      req_ch.x_pins   <= '0;
      req_ch.y_pins   <= '0;
      req_ch.target_x <= '0;
      req_ch.target_y <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      gain_p_model = GAIN_P_RESET;
      gain_d_model = GAIN_D_RESET;
      quad_now      = '{2'b00, 2'b00};
      quad_prev     = '{2'b00, 2'b00};
      axis_pos      = '{'0, '0};
      axis_last_err = '{'0, '0};
      servo_on = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_decoder_edges();
      test_servo_modes();
      test_gain_sweep();
      test_backpressure();
      test_random_traffic();
      settle();
      $display("Run covered %0d commands and %0d drive beats over %0d gain settings.",
               commands_sent, drives_checked, gain_settings);
      $display("Saw %0d saturated axis drives and %0d decoder error samples.",
               saturated_drives, decoder_faults);
      if (error_count == 0) begin
         $display("quadrature_pd_servo_two_axis_tb: done, clean");
      end else begin
         $display("quadrature_pd_servo_two_axis_tb: done, errors");
      end
      $finish;
   end

endmodule

### quadrature_pd_servo_two_axis.f
hw/rtl/qps_pkg.sv
hw/rtl/qps_chan_if.sv
hw/rtl/quadrature_pd_servo_two_axis.sv
dv/quadrature_pd_servo_two_axis_tb.sv
